>>> src/pmta_pkg.sv
`timescale 1ns / 1ps
package pmta_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int MARK_W      = 31;
    localparam int CNT_W       = 64;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 296;

    typedef enum logic [2:0] {
        CMD_BEGIN   = 3'd0,
        CMD_DUMP    = 3'd1,
        CMD_DESTROY = 3'd2,
        CMD_DENIED  = 3'd3,
        CMD_EXPORT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic CFG_IN_MARK_BASE = 1'b0;
    localparam logic CFG_MARK_DELTA   = 1'b1;

    // One accepted command as it passes from the front part to the back part.
    typedef struct packed {
        logic [2:0]        command;
        logic [MARK_W-1:0] mark;
        logic [CNT_W-1:0]  reply_bytes;
        logic [CNT_W-1:0]  orig_bytes;
        logic              direction;
        logic [MARK_W-1:0] denied_bytes;
    } cmd_word_t;

    // One result word.
    typedef struct packed {
        logic              last;
        logic [CNT_W-1:0]  denied_out_total;
        logic [CNT_W-1:0]  denied_in_total;
        logic [CNT_W-1:0]  allowed_out_total;
        logic [CNT_W-1:0]  allowed_in_total;
        logic [MARK_W-1:0] export_mark;
        logic              entry_valid;
        logic [1:0]        status;
    } res_word_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SEARCH,
        B_CLEAR,
        B_UPDATE,
        B_EMIT,
        B_EX_READ,
        B_EX_WAIT,
        B_EX_MATCH,
        B_EX_OUT,
        B_EX_OUTWAIT,
        B_EX_OUTSEND
    } bstate_t;

endpackage

>>> src/pmta_ram.sv
`timescale 1ns / 1ps
module pmta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/pmta_front.sv
`timescale 1ns / 1ps
module pmta_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pmta_pkg::cmd_word_t   in_word,
    output logic                  q_valid,
    input  logic                  q_ready,
    output pmta_pkg::cmd_word_t   q_word
);

    // Two-entry queue between the stream input and the back part.
    pmta_pkg::cmd_word_t slot_reg [2];
    logic                rd_ptr_reg, wr_ptr_reg;
    logic [1:0]          fill_reg;
    logic                push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_word   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

>>> src/pmta_back.sv
`timescale 1ns / 1ps
module pmta_back #(
    parameter int ENTRIES = pmta_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pmta_pkg::MARK_W-1:0]   in_mark_base,
    input  logic [pmta_pkg::MARK_W-1:0]   mark_delta,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  pmta_pkg::cmd_word_t           q_word,
    output logic                          res_valid,
    input  logic                          res_ready,
    output pmta_pkg::res_word_t           res_word
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = pmta_pkg::MARK_W;
    localparam int DW = pmta_pkg::CNT_W;
    // Slot memory row: key and six counters.
    localparam int RW = MW + 6 * DW;
    // Merge memory row: mark and four totals.
    localparam int XW = MW + 4 * DW;

    // Keys are kept in flip-flops so the search reads one per cycle directly.
    logic [MW-1:0]       key_reg [ENTRIES];
    logic [CW-1:0]       count_reg, count_next;
    // One bit per slot says whether its live pair is current; begin-dump clears them all.
    logic [ENTRIES-1:0]  live_vld_reg;

    pmta_pkg::bstate_t   state_reg, state_next;
    pmta_pkg::cmd_word_t cmd_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic                found_reg, found_next;
    logic [1:0]          status_reg, status_next;
    pmta_pkg::res_word_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // Export merge list.
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [MW-1:0]       xmark_reg [ENTRIES];
    logic [4*DW-1:0]     sw_reg, sw_next, st_reg, st_next;
    logic [MW-1:0]       ckey_reg, ckey_next, cfold_reg, cfold_next;
    logic                cin_reg, cin_next;

    // Slot memory.
    logic                s_we;
    logic [AW-1:0]       s_waddr, s_raddr;
    logic [RW-1:0]       s_wdata, s_rdata;
    // Merge memory.
    logic                x_we;
    logic [AW-1:0]       x_waddr, x_raddr;
    logic [XW-1:0]       x_wdata, x_rdata;
    logic                xm_we;
    logic [AW-1:0]       xm_addr;
    logic [MW-1:0]       xm_data;
    logic                key_we;

    pmta_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_slots (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    pmta_ram #(.WIDTH(XW), .DEPTH(ENTRIES)) u_merge (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rdata)
    );

    // Fields of the slot row read back; live counters read as zero when stale.
    logic [DW-1:0] r_li, r_lo, r_ri, r_ro, r_bi, r_bo;
    logic          live_ok;
    assign live_ok = live_vld_reg[slot_reg];
    assign r_li = live_ok ? s_rdata[6*DW-1:5*DW] : '0;
    assign r_lo = live_ok ? s_rdata[5*DW-1:4*DW] : '0;
    assign r_ri = s_rdata[4*DW-1:3*DW];
    assign r_ro = s_rdata[3*DW-1:2*DW];
    assign r_bi = s_rdata[2*DW-1:DW];
    assign r_bo = s_rdata[DW-1:0];

    logic [AW-1:0] idx_a, j_a, n_a;
    assign idx_a = idx_reg[AW-1:0];
    assign j_a   = j_reg[AW-1:0];
    assign n_a   = n_reg[AW-1:0];

    logic [DW-1:0] ain, aout;
    assign ain  = r_li + r_ri;
    assign aout = r_lo + r_ro;

    logic [DW-1:0] dbx;
    assign dbx = {{(DW-MW){1'b0}}, cmd_reg.denied_bytes};

    logic match_sw, match_st;
    assign match_sw = cin_reg && (cfold_reg == xmark_reg[j_a]);
    assign match_st = (ckey_reg == xmark_reg[j_a]);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        sw_next        = sw_reg;
        st_next        = st_reg;
        ckey_next      = ckey_reg;
        cfold_next     = cfold_reg;
        cin_next       = cin_reg;
        q_ready        = 1'b0;
        s_we           = 1'b0;
        s_waddr        = slot_reg;
        s_wdata        = '0;
        s_raddr        = slot_reg;
        x_we           = 1'b0;
        x_waddr        = j_a;
        x_wdata        = '0;
        x_raddr        = j_a;
        xm_we          = 1'b0;
        xm_addr        = n_a;
        xm_data        = ckey_reg;
        key_we         = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pmta_pkg::B_IDLE:
            begin
                q_ready     = !out_valid_reg;
                idx_next    = '0;
                found_next  = 1'b0;
                status_next = pmta_pkg::ST_OK;
                n_next      = '0;
                if (q_valid && !out_valid_reg)
                begin
                    unique case (q_word.command)
                        pmta_pkg::CMD_BEGIN:   state_next = pmta_pkg::B_CLEAR;
                        pmta_pkg::CMD_EXPORT:  state_next = pmta_pkg::B_EX_READ;
                        pmta_pkg::CMD_DUMP,
                        pmta_pkg::CMD_DESTROY,
                        pmta_pkg::CMD_DENIED:
                        begin
                            if (q_word.mark == '0)
                            begin
                                status_next = pmta_pkg::ST_ZERO;
                                state_next  = pmta_pkg::B_EMIT;
                            end
                            else
                            begin
                                state_next = pmta_pkg::B_SEARCH;
                            end
                        end
                        default:               state_next = pmta_pkg::B_EMIT;
                    endcase
                end
            end

            pmta_pkg::B_CLEAR:
            begin
                state_next = pmta_pkg::B_EMIT;
            end

            // Linear key search, one slot per cycle.
            pmta_pkg::B_SEARCH:
            begin
                if (idx_reg < count_reg && !found_reg)
                begin
                    if (key_reg[idx_a] == cmd_reg.mark)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx_a;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (found_reg)
                    begin
                        state_next = pmta_pkg::B_UPDATE;
                    end
                    else if (cmd_reg.command == pmta_pkg::CMD_DESTROY)
                    begin
                        status_next = pmta_pkg::ST_NOTFOUND;
                        state_next  = pmta_pkg::B_EMIT;
                    end
                    else if (count_reg == CW'(ENTRIES))
                    begin
                        status_next = pmta_pkg::ST_FULL;
                        state_next  = pmta_pkg::B_EMIT;
                    end
                    else
                    begin
                        // Insert with all counters zero, then update.
                        slot_next  = count_reg[AW-1:0];
                        s_waddr    = count_reg[AW-1:0];
                        s_we       = 1'b1;
                        s_wdata    = {cmd_reg.mark, {(6*DW){1'b0}}};
                        key_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = pmta_pkg::B_SEARCH;
                        found_next = 1'b1;
                        idx_next   = count_reg + 1'b1;
                    end
                end
                s_raddr = found_reg ? slot_reg : slot_next;
            end

            pmta_pkg::B_UPDATE:
            begin
                s_we    = 1'b1;
                s_wdata = {cmd_reg.mark, r_li, r_lo, r_ri, r_ro, r_bi, r_bo};
                unique case (cmd_reg.command)
                    pmta_pkg::CMD_DUMP:
                        s_wdata = {cmd_reg.mark, r_li + cmd_reg.reply_bytes,
                                   r_lo + cmd_reg.orig_bytes, r_ri, r_ro, r_bi, r_bo};
                    pmta_pkg::CMD_DESTROY:
                        s_wdata = {cmd_reg.mark, r_li, r_lo, r_ri + cmd_reg.reply_bytes,
                                   r_ro + cmd_reg.orig_bytes, r_bi, r_bo};
                    default:
                        s_wdata = cmd_reg.direction
                            ? {cmd_reg.mark, r_li, r_lo, r_ri, r_ro, r_bi, r_bo + dbx}
                            : {cmd_reg.mark, r_li, r_lo, r_ri, r_ro, r_bi + dbx, r_bo};
                endcase
                state_next = pmta_pkg::B_EMIT;
            end

            pmta_pkg::B_EMIT:
            begin
                out_next        = '0;
                out_next.status = status_reg;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = pmta_pkg::B_IDLE;
            end

            // Export: read slot idx.
            pmta_pkg::B_EX_READ:
            begin
                if (idx_reg < count_reg)
                begin
                    slot_next  = idx_a;
                    s_raddr    = idx_a;
                    state_next = pmta_pkg::B_EX_WAIT;
                end
                else
                begin
                    j_next     = '0;
                    state_next = pmta_pkg::B_EX_OUT;
                    if (n_reg == '0)
                    begin
                        status_next = pmta_pkg::ST_OK;
                        state_next  = pmta_pkg::B_EMIT;
                    end
                end
            end

            pmta_pkg::B_EX_WAIT:
            begin
                ckey_next  = s_rdata[RW-1:6*DW];
                cin_next   = (s_rdata[RW-1:6*DW] >= in_mark_base);
                cfold_next = s_rdata[RW-1:6*DW] - mark_delta;
                sw_next    = {aout, ain, r_bo, r_bi};
                st_next    = {ain, aout, r_bi, r_bo};
                j_next     = '0;
                state_next = pmta_pkg::B_EX_MATCH;
            end

            // Walk merge list; read row j ahead, add on match.
            pmta_pkg::B_EX_MATCH:
            begin
                if (j_reg < n_reg)
                begin
                    if (match_sw || match_st)
                    begin
                        state_next = pmta_pkg::B_EX_OUTWAIT;
                        slot_next  = j_a;
                        x_raddr    = j_a;
                        found_next = match_sw;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    x_we       = 1'b1;
                    x_waddr    = n_a;
                    xm_we      = 1'b1;
                    xm_addr    = n_a;
                    xm_data    = cin_reg ? cfold_reg : ckey_reg;
                    x_wdata    = {xm_data, cin_reg ? sw_reg : st_reg};
                    n_next     = n_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = pmta_pkg::B_EX_READ;
                end
            end

            // Read-modify-write of merge row slot_reg.
            pmta_pkg::B_EX_OUTWAIT:
            begin
                x_we     = 1'b1;
                x_waddr  = slot_reg;
                x_wdata  = {x_rdata[XW-1:4*DW],
                    x_rdata[4*DW-1:3*DW] + (found_reg ? sw_reg[4*DW-1:3*DW]
                                                      : st_reg[4*DW-1:3*DW]),
                    x_rdata[3*DW-1:2*DW] + (found_reg ? sw_reg[3*DW-1:2*DW]
                                                      : st_reg[3*DW-1:2*DW]),
                    x_rdata[2*DW-1:DW]   + (found_reg ? sw_reg[2*DW-1:DW]
                                                      : st_reg[2*DW-1:DW]),
                    x_rdata[DW-1:0]      + (found_reg ? sw_reg[DW-1:0] : st_reg[DW-1:0])};
                idx_next   = idx_reg + 1'b1;
                state_next = pmta_pkg::B_EX_READ;
            end

            // Emission: read row j, send it.
            pmta_pkg::B_EX_OUT:
            begin
                x_raddr = j_a;
                if (!out_valid_reg)
                begin
                    state_next = pmta_pkg::B_EX_OUTSEND;
                end
            end

            pmta_pkg::B_EX_OUTSEND:
            begin
                out_next.status            = pmta_pkg::ST_OK;
                out_next.entry_valid       = 1'b1;
                out_next.export_mark       = x_rdata[XW-1:4*DW];
                out_next.allowed_in_total  = x_rdata[4*DW-1:3*DW];
                out_next.allowed_out_total = x_rdata[3*DW-1:2*DW];
                out_next.denied_in_total   = x_rdata[2*DW-1:DW];
                out_next.denied_out_total  = x_rdata[DW-1:0];
                out_next.last              = (j_reg + 1'b1 == n_reg);
                out_valid_next             = 1'b1;
                j_next                     = j_reg + 1'b1;
                state_next = (j_reg + 1'b1 == n_reg) ? pmta_pkg::B_IDLE
                                                     : pmta_pkg::B_EX_OUT;
            end

            default: state_next = pmta_pkg::B_IDLE;
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmta_pkg::B_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            live_vld_reg   <= '0;
            n_reg          <= '0;
            j_reg          <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            status_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            // Begin-dump drops every slot's live pair; any slot write makes it current.
            if (state_reg == pmta_pkg::B_CLEAR)
            begin
                live_vld_reg <= '0;
            end
            else if (s_we)
            begin
                live_vld_reg[s_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        sw_reg    <= sw_next;
        st_reg    <= st_next;
        ckey_reg  <= ckey_next;
        cfold_reg <= cfold_next;
        cin_reg   <= cin_next;
        slot_reg  <= slot_next;
        if (q_valid && q_ready)
        begin
            cmd_reg <= q_word;
        end
        if (key_we)
        begin
            key_reg[count_reg[AW-1:0]] <= cmd_reg.mark;
        end
        if (xm_we)
        begin
            xmark_reg[xm_addr] <= xm_data;
        end
    end

endmodule

>>> src/per_mark_traffic_accounting_table.sv
`timescale 1ns / 1ps
// Per-mark byte accounting table of ENTRIES slots kept in insertion order.
// A small input queue decouples the stream from a sequencer that searches keys
// one slot per clock for a dump, destroy or denied word. A begin-dump drops
// live counters by clearing one valid bit per slot. An export reads each slot
// and walks the merge list for it, then sends one result word per merged
// entry while the receiver is ready. Counters sit in a single-port-write memory
// with registered read. The next word is taken only once the previous result
// word has left. Results of one command end with tlast; no clearing pass after
// reset.
module per_mark_traffic_accounting_table #(
    parameter int ENTRIES = pmta_pkg::ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[2:0], mark[33:3], reply_bytes[97:34], orig_bytes[161:98],
    // direction[162], denied_bytes[193:163], zero fill
    input  logic [pmta_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], entry_valid[2], export_mark[33:3], allowed_in_total[97:34],
    // allowed_out_total[161:98], denied_in_total[225:162],
    // denied_out_total[289:226], zero fill
    output logic [pmta_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic         m_tlast
);

    logic [30:0]         in_mark_base_reg, mark_delta_reg;
    pmta_pkg::cmd_word_t in_word, q_word;
    pmta_pkg::res_word_t res_word;
    logic                q_valid, q_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_mark_base_reg <= 31'h4000_0000;
            mark_delta_reg   <= 31'h4000_0000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pmta_pkg::CFG_IN_MARK_BASE)
            begin
                in_mark_base_reg <= cfg_data;
            end
            else
            begin
                mark_delta_reg <= cfg_data;
            end
        end
    end

    assign in_word.command      = s_tdata[2:0];
    assign in_word.mark         = s_tdata[33:3];
    assign in_word.reply_bytes  = s_tdata[97:34];
    assign in_word.orig_bytes   = s_tdata[161:98];
    assign in_word.direction    = s_tdata[162];
    assign in_word.denied_bytes = s_tdata[193:163];

    pmta_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_word(in_word),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    pmta_back #(.ENTRIES(ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_mark_base(in_mark_base_reg), .mark_delta(mark_delta_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_word(res_word)
    );

    assign m_tdata = {6'd0, res_word.denied_out_total, res_word.denied_in_total,
                      res_word.allowed_out_total, res_word.allowed_in_total,
                      res_word.export_mark, res_word.entry_valid, res_word.status};
    assign m_tlast = res_word.last;

endmodule

>>> src/pmta_checker.sv
`timescale 1ns / 1ps
module pmta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [295:0] m_tdata,
    input logic        m_tlast
);

    // A held result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A word without an export entry is always the last of its command.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tlast)
        else $error("non-export word not last");

    // Non-export words carry zero totals.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[295:3] == '0)
        else $error("non-export word has payload");

    // Export entries always report status ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
        else $error("export entry with bad status");

endmodule

bind per_mark_traffic_accounting_table pmta_checker u_pmta_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
